// ===== hdl/kdpc_pkg.sv =====
package kdpc_pkg;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_SHORT_PRESS  = 3'd0;
	localparam logic [2:0] REG_LONG_PRESS   = 3'd1;
	localparam logic [2:0] REG_RELEASE      = 3'd2;
	localparam logic [2:0] REG_DOUBLE_HIT   = 3'd3;
	localparam logic [2:0] REG_POST_HOLDOFF = 3'd4;

	// Reset values of the registers.
	localparam logic [6:0] SHORT_PRESS_RST  = 7'd4;
	localparam logic [7:0] LONG_PRESS_RST   = 8'd100;
	localparam logic [7:0] RELEASE_RST      = 8'd4;
	localparam logic [7:0] DOUBLE_HIT_RST   = 8'd50;
	localparam logic [7:0] POST_HOLDOFF_RST = 8'd10;

	// Button patterns, active low: bit0 power, bit1 mode, bit2 rate, bit3 center.
	localparam logic [3:0] PAT_NONE        = 4'hF;
	localparam logic [3:0] PAT_POWER       = 4'hE;
	localparam logic [3:0] PAT_MODE        = 4'hD;
	localparam logic [3:0] PAT_POWER_MODE  = 4'hC;
	localparam logic [3:0] PAT_RATE        = 4'hB;
	localparam logic [3:0] PAT_CENTER      = 4'h7;
	localparam logic [3:0] PAT_CENTER_RATE = 4'h3;

	// Encoder transitions, previous phase in the upper two bits.
	localparam logic [3:0] TR_CW_A  = 4'h4;
	localparam logic [3:0] TR_CW_B  = 4'hB;
	localparam logic [3:0] TR_CCW_A = 4'h7;
	localparam logic [3:0] TR_CCW_B = 4'h8;

	// Key codes.
	localparam logic [3:0] KEY_POWER            = 4'd0;
	localparam logic [3:0] KEY_MODE             = 4'd1;
	localparam logic [3:0] KEY_RATE             = 4'd2;
	localparam logic [3:0] KEY_CENTER           = 4'd3;
	localparam logic [3:0] KEY_LONG_POWER       = 4'd4;
	localparam logic [3:0] KEY_LONG_MODE        = 4'd5;
	localparam logic [3:0] KEY_LONG_POWER_MODE  = 4'd6;
	localparam logic [3:0] KEY_LONG_RATE        = 4'd7;
	localparam logic [3:0] KEY_LONG_CENTER      = 4'd8;
	localparam logic [3:0] KEY_LONG_CENTER_RATE = 4'd9;
	localparam logic [3:0] KEY_CW               = 4'd10;
	localparam logic [3:0] KEY_CCW              = 4'd11;

	typedef struct packed {
		logic [6:0] short_press;
		logic [7:0] long_press;
		logic [7:0] release_len;
		logic [7:0] double_hit;
		logic [7:0] post_holdoff;
	} kdpc_cfg_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] code;
	} kdpc_result_t;

	function automatic kdpc_result_t map_short(input logic [3:0] pat);
		kdpc_result_t r;
		r.valid = 1'b1;
		case (pat)
			PAT_POWER:  r.code = KEY_POWER;
			PAT_MODE:   r.code = KEY_MODE;
			PAT_RATE:   r.code = KEY_RATE;
			PAT_CENTER: r.code = KEY_CENTER;
			default: begin
				r.valid = 1'b0;
				r.code  = KEY_POWER;
			end
		endcase
		return r;
	endfunction

	function automatic kdpc_result_t map_long(input logic [3:0] pat);
		kdpc_result_t r;
		r.valid = 1'b1;
		case (pat)
			PAT_POWER:       r.code = KEY_LONG_POWER;
			PAT_MODE:        r.code = KEY_LONG_MODE;
			PAT_POWER_MODE:  r.code = KEY_LONG_POWER_MODE;
			PAT_RATE:        r.code = KEY_LONG_RATE;
			PAT_CENTER:      r.code = KEY_LONG_CENTER;
			PAT_CENTER_RATE: r.code = KEY_LONG_CENTER_RATE;
			default: begin
				r.valid = 1'b0;
				r.code  = KEY_POWER;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/key_debounce_press_classifier.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    action, buttons_n, enc_ab
// output    out        out_valid/out_ready  key_code
// config    in         cfg_we               cfg_index, cfg_data
//
// One request is taken per cycle while in_ready is high: its whole update is combinational
// counter and compare logic in kdpc_core, and a result lands in the output register the
// next cycle. A new request is accepted while the output register is empty or being
// emptied, so a stalled output holds only the input side, never the state.
// Reset clears all counters, the encoder phase, the configuration to its defaults and
// the output valid flag; the early button samples are written by the first presses.
module key_debounce_press_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [3:0] buttons_n,
	input  logic [1:0] enc_ab,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] key_code,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	kdpc_pkg::kdpc_cfg_t    cfg_q;
	kdpc_pkg::kdpc_result_t result;
	logic                   out_valid_q;
	logic [3:0]             key_code_q;
	logic                   step;

	// The output register parts the two sides: a waiting result only blocks a new
	// request when the consumer is not taking it in this same cycle.
	assign in_ready  = !out_valid_q || out_ready;
	assign step      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign key_code  = key_code_q;

	// Configuration writes; an index beyond the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_press  <= kdpc_pkg::SHORT_PRESS_RST;
			cfg_q.long_press   <= kdpc_pkg::LONG_PRESS_RST;
			cfg_q.release_len  <= kdpc_pkg::RELEASE_RST;
			cfg_q.double_hit   <= kdpc_pkg::DOUBLE_HIT_RST;
			cfg_q.post_holdoff <= kdpc_pkg::POST_HOLDOFF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kdpc_pkg::REG_SHORT_PRESS:  cfg_q.short_press  <= cfg_data[6:0];
				kdpc_pkg::REG_LONG_PRESS:   cfg_q.long_press   <= cfg_data;
				kdpc_pkg::REG_RELEASE:      cfg_q.release_len  <= cfg_data;
				kdpc_pkg::REG_DOUBLE_HIT:   cfg_q.double_hit   <= cfg_data;
				kdpc_pkg::REG_POST_HOLDOFF: cfg_q.post_holdoff <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	kdpc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.action    (action),
		.buttons_n (buttons_n),
		.enc_ab    (enc_ab),
		.cfg       (cfg_q),
		.result    (result)
	);

	// A request that yields no code simply empties the register, which is safe
	// because it can only be accepted when the old result is gone or going.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= result.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && result.valid) begin
			key_code_q <= result.code;
		end
	end

	a_code_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> key_code <= kdpc_pkg::KEY_CCW)
		else $error("key code out of range");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.valid |=> out_valid && key_code == $past(result.code))
		else $error("emitted code did not reach the output register");

	a_no_result_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step && !(out_valid && !out_ready) |=> !out_valid)
		else $error("output appeared without a request");

endmodule

// ===== hdl/kdpc_core.sv =====
module kdpc_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic                     action,
	input  logic [3:0]               buttons_n,
	input  logic [1:0]               enc_ab,
	input  kdpc_pkg::kdpc_cfg_t      cfg,
	output kdpc_pkg::kdpc_result_t   result
);

	logic [7:0] held_q, released_q, lockout_q, holdoff_q;
	logic [1:0] phase_q;
	logic [3:0] es_q [3];

	logic [7:0] held_d, released_d, lockout_d, holdoff_d;
	logic [1:0] phase_d;
	logic [3:0] es_d [3];

	logic [7:0] holdoff_dec, held_inc, released_inc;
	logic [3:0] trans, key;
	logic       key_ok;
	kdpc_pkg::kdpc_result_t code;

	assign holdoff_dec  = (holdoff_q != 8'd0) ? holdoff_q - 8'd1 : 8'd0;
	assign held_inc     = held_q + 8'd1;
	assign released_inc = released_q + 8'd1;
	assign trans        = {phase_q, enc_ab};

	// Majority vote over the first three samples of the press.
	always_comb begin
		key_ok = 1'b1;
		key    = es_q[0];
		if (es_q[0] == es_q[1] || es_q[0] == es_q[2]) begin
			key = es_q[0];
		end else if (es_q[1] == es_q[2]) begin
			key = es_q[1];
		end else begin
			key_ok = 1'b0;
		end
		if (held_q == cfg.long_press) begin
			code = kdpc_pkg::map_long(key);
		end else begin
			code = kdpc_pkg::map_short(key);
		end
	end

	always_comb begin
		held_d     = held_q;
		released_d = released_q;
		lockout_d  = lockout_q;
		holdoff_d  = holdoff_q;
		phase_d    = phase_q;
		es_d       = es_q;
		result     = '0;
		if (action) begin
			// Encoder ticks do not count the spacing down.
			phase_d = enc_ab;
			case (trans)
				kdpc_pkg::TR_CW_A, kdpc_pkg::TR_CW_B: begin
					result.code = kdpc_pkg::KEY_CW;
					result.valid = (holdoff_q == 8'd0);
				end
				kdpc_pkg::TR_CCW_A, kdpc_pkg::TR_CCW_B: begin
					result.code = kdpc_pkg::KEY_CCW;
					result.valid = (holdoff_q == 8'd0);
				end
				default: result = '0;
			endcase
			if (result.valid) begin
				holdoff_d = cfg.post_holdoff;
			end
		end else begin
			holdoff_d = holdoff_dec;
			if (buttons_n != kdpc_pkg::PAT_NONE) begin
				released_d = 8'd0;
				held_d     = held_inc;
				if (held_inc == 8'd1) begin
					es_d[0] = buttons_n;
				end else if (held_inc == 8'd2) begin
					es_d[1] = buttons_n;
					if (es_q[0] != buttons_n) begin
						es_d[0] = buttons_n;
						held_d  = 8'd1;
					end
				end else if (held_inc == 8'd3) begin
					es_d[2] = buttons_n;
					if (es_q[1] != buttons_n) begin
						es_d[0] = buttons_n;
						held_d  = 8'd1;
					end
				end else if (es_q[0] != buttons_n) begin
					es_d[0] = buttons_n;
					held_d  = 8'd1;
				end else if (held_inc > cfg.long_press) begin
					held_d = cfg.long_press;
				end
			end else if (released_inc < cfg.release_len) begin
				released_d = released_inc;
			end else begin
				released_d = cfg.release_len;
				if (lockout_q != 8'd0) begin
					lockout_d = lockout_q - 8'd1;
					held_d    = 8'd0;
				end else if (held_q >= {1'b0, cfg.short_press}) begin
					// A press below the short length leaves the count alone.
					held_d = 8'd0;
					if (key_ok && code.valid) begin
						lockout_d = cfg.double_hit;
						if (holdoff_dec == 8'd0) begin
							result    = code;
							holdoff_d = cfg.post_holdoff;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			released_q <= '0;
			lockout_q  <= '0;
			holdoff_q  <= '0;
			phase_q    <= '0;
		end else if (step) begin
			held_q     <= held_d;
			released_q <= released_d;
			lockout_q  <= lockout_d;
			holdoff_q  <= holdoff_d;
			phase_q    <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			es_q <= es_d;
		end
	end

	a_emit_loads_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.valid |=> holdoff_q == $past(cfg.post_holdoff))
		else $error("holdoff not reloaded after an emitted code");

	a_scan_emit_arms_lockout: assert property (@(posedge clk) disable iff (!arst_n)
		step && !action && result.valid |=> lockout_q == $past(cfg.double_hit))
		else $error("lockout not armed after an emitted key");

	a_encoder_keeps_press: assert property (@(posedge clk) disable iff (!arst_n)
		step && action |=> held_q == $past(held_q) && released_q == $past(released_q)
			&& lockout_q == $past(lockout_q))
		else $error("encoder tick disturbed the press counters");

	a_scan_counts_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		step && !action && !result.valid |=> holdoff_q == $past(holdoff_dec))
		else $error("holdoff did not count down on a scan tick");

endmodule

// ===== sim/tb_key_debounce_press_classifier.sv =====
module tb_key_debounce_press_classifier;
	timeunit 1ns;
	timeprecision 1ps;

	// A request is either a button scan or an encoder sample.
	localparam logic ACT_SCAN = 1'b0;
	localparam logic ACT_ENC  = 1'b1;

	// Register indexes past the last register must be ignored by the block.
	localparam logic [2:0] REG_SPARE_FIRST = kdpc_pkg::REG_POST_HOLDOFF + 3'd1;

	localparam int unsigned SETTLE_CYCLES   = 4;
	localparam int unsigned RX_STALL_CYCLES = 60;
	localparam int unsigned WATCHDOG_LIMIT  = 2000;
	localparam int          NUM_PHASES      = 9;

	typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;

	// One row of the directed table. Rows with typed set carry their own expected
	// result; all other rows are checked against the press predictor.
	typedef struct {
		row_kind_t  kind;
		logic       act;
		logic [3:0] btn;
		logic [1:0] ab;
		bit         typed;
		bit         exp_emit;
		logic [3:0] exp_code;
		logic [2:0] reg_idx;
		logic [7:0] reg_val;
	} dir_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic       action    = ACT_SCAN;
	logic [3:0] buttons_n = kdpc_pkg::PAT_NONE;
	logic [1:0] enc_ab    = 2'b00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [3:0] key_code;
	logic       cfg_we    = 1'b0;
	logic [2:0] cfg_index = kdpc_pkg::REG_SHORT_PRESS;
	logic [7:0] cfg_data  = 8'd0;

	key_debounce_press_classifier dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.buttons_n(buttons_n),
		.enc_ab   (enc_ab),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.key_code (key_code),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Predictor state. These mirror the block's counters and registers and are
	// advanced once for every request the block accepts.
	kdpc_pkg::kdpc_cfg_t cfg_now;
	logic [7:0] held_ticks;
	logic [7:0] release_run;
	logic [7:0] lockout_left;
	logic [7:0] spacing_left;
	logic [3:0] first_samples [3];
	logic [1:0] last_phase;

	// Key codes that the block still owes us, oldest first.
	logic [3:0] expected_keys [$];

	// Handshake pacing. The sender side is paced from the main process, the
	// receiver side from its own process below.
	int unsigned valid_idle_pct = 0;
	int unsigned ready_idle_pct = 0;
	logic        stall_toggle   = 1'b0;
	logic        stall_seen     = 1'b0;
	int unsigned stall_left     = 0;

	int unsigned errors       = 0;
	int unsigned keys_checked = 0;
	int unsigned scan_sent    = 0;
	int unsigned enc_sent     = 0;
	int unsigned settings_run = 0;
	logic [1:0]  enc_last     = 2'b00;

	initial begin
		forever #10 clk = ~clk;
	end

	// Work out what one accepted request does to the block and whether it emits a
	// key code. Encoder samples emit on a quarter step out of phase 01 or 10; scan
	// ticks debounce the buttons and judge the held pattern after a release.
	function automatic void predict_key(input logic act, input logic [3:0] btn,
			input logic [1:0] ab, output bit emits, output logic [3:0] code);
		logic [3:0] trans;
		logic [3:0] key;
		logic [3:0] found;
		bit         mapped;

		emits  = 1'b0;
		code   = kdpc_pkg::KEY_POWER;
		mapped = 1'b0;
		found  = kdpc_pkg::KEY_POWER;

		if (act == ACT_ENC) begin
			trans      = {last_phase, ab};
			last_phase = ab;
			case (trans)
				kdpc_pkg::TR_CW_A, kdpc_pkg::TR_CW_B: begin
					mapped = 1'b1;
					found  = kdpc_pkg::KEY_CW;
				end
				kdpc_pkg::TR_CCW_A, kdpc_pkg::TR_CCW_B: begin
					mapped = 1'b1;
					found  = kdpc_pkg::KEY_CCW;
				end
				default: ;
			endcase
			// Encoder samples respect the spacing but never count it down.
			if (mapped && spacing_left == 8'd0) begin
				emits        = 1'b1;
				code         = found;
				spacing_left = cfg_now.post_holdoff;
			end
			return;
		end

		if (spacing_left != 8'd0)
			spacing_left = spacing_left - 8'd1;

		if (btn != kdpc_pkg::PAT_NONE) begin
			// Something is pressed: count the hold and make sure the first three
			// samples agree, restarting whenever the pattern moves.
			held_ticks  = held_ticks + 8'd1;
			release_run = 8'd0;
			if (held_ticks == 8'd1) begin
				first_samples[0] = btn;
			end else if (held_ticks == 8'd2) begin
				first_samples[1] = btn;
				if (first_samples[0] != first_samples[1]) begin
					first_samples[0] = first_samples[1];
					held_ticks       = 8'd1;
				end
			end else if (held_ticks == 8'd3) begin
				first_samples[2] = btn;
				if (first_samples[1] != first_samples[2]) begin
					first_samples[0] = first_samples[2];
					held_ticks       = 8'd1;
				end
			end else if (first_samples[0] != btn) begin
				first_samples[0] = btn;
				held_ticks       = 8'd1;
			end else if (held_ticks > cfg_now.long_press) begin
				held_ticks = cfg_now.long_press;
			end
			return;
		end

		// All buttons up. Nothing is judged until the release has lasted long enough.
		release_run = release_run + 8'd1;
		if (release_run < cfg_now.release_len)
			return;
		release_run = cfg_now.release_len;

		// Each judged release during the lockout burns one lockout tick.
		if (lockout_left != 8'd0) begin
			lockout_left = lockout_left - 8'd1;
			held_ticks   = 8'd0;
			return;
		end
		// A press that was too short keeps its count, which the next press carries on.
		if (held_ticks < {1'b0, cfg_now.short_press})
			return;

		if (first_samples[0] == first_samples[1] || first_samples[0] == first_samples[2]) begin
			key = first_samples[0];
		end else if (first_samples[1] == first_samples[2]) begin
			key = first_samples[1];
		end else begin
			held_ticks = 8'd0;
			return;
		end

		mapped = 1'b1;
		if (held_ticks == cfg_now.long_press) begin
			case (key)
				kdpc_pkg::PAT_POWER:       found = kdpc_pkg::KEY_LONG_POWER;
				kdpc_pkg::PAT_MODE:        found = kdpc_pkg::KEY_LONG_MODE;
				kdpc_pkg::PAT_POWER_MODE:  found = kdpc_pkg::KEY_LONG_POWER_MODE;
				kdpc_pkg::PAT_RATE:        found = kdpc_pkg::KEY_LONG_RATE;
				kdpc_pkg::PAT_CENTER:      found = kdpc_pkg::KEY_LONG_CENTER;
				kdpc_pkg::PAT_CENTER_RATE: found = kdpc_pkg::KEY_LONG_CENTER_RATE;
				default:                   mapped = 1'b0;
			endcase
		end else begin
			case (key)
				kdpc_pkg::PAT_POWER:  found = kdpc_pkg::KEY_POWER;
				kdpc_pkg::PAT_MODE:   found = kdpc_pkg::KEY_MODE;
				kdpc_pkg::PAT_RATE:   found = kdpc_pkg::KEY_RATE;
				kdpc_pkg::PAT_CENTER: found = kdpc_pkg::KEY_CENTER;
				default:              mapped = 1'b0;
			endcase
		end

		// A recognized key always arms the lockout, even when the spacing swallows it.
		if (mapped) begin
			if (spacing_left == 8'd0) begin
				emits        = 1'b1;
				code         = found;
				spacing_left = cfg_now.post_holdoff;
			end
			lockout_left = cfg_now.double_hit;
		end
		held_ticks = 8'd0;
	endfunction

	function automatic dir_row_t req_row(input logic act, input logic [3:0] btn,
			input logic [1:0] ab, input bit typed = 1'b0, input bit exp_emit = 1'b0,
			input logic [3:0] exp_code = kdpc_pkg::KEY_POWER);
		dir_row_t r;

		r.kind     = ROW_REQUEST;
		r.act      = act;
		r.btn      = btn;
		r.ab       = ab;
		r.typed    = typed;
		r.exp_emit = exp_emit;
		r.exp_code = exp_code;
		r.reg_idx  = kdpc_pkg::REG_SHORT_PRESS;
		r.reg_val  = 8'd0;
		return r;
	endfunction

	function automatic dir_row_t write_row(input logic [2:0] idx, input logic [7:0] val);
		dir_row_t r;

		r          = req_row(ACT_SCAN, kdpc_pkg::PAT_NONE, 2'b00);
		r.kind     = ROW_WRITE;
		r.reg_idx  = idx;
		r.reg_val  = val;
		return r;
	endfunction

	// Offer one request and hold it until the block takes it. The predictor runs at
	// the edge of acceptance. A typed row overrides what the predictor expects.
	task automatic send_request(input logic act, input logic [3:0] btn, input logic [1:0] ab,
			input bit typed = 1'b0, input bit exp_emit = 1'b0,
			input logic [3:0] exp_code = kdpc_pkg::KEY_POWER);
		bit         emits;
		logic [3:0] code;

		while ($urandom_range(99) < valid_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		buttons_n <= btn;
		enc_ab    <= ab;
		do
			@(posedge clk);
		while (!in_ready);

		predict_key(act, btn, ab, emits, code);
		if (typed) begin
			emits = exp_emit;
			code  = exp_code;
		end
		if (emits)
			expected_keys.push_back(code);
		if (act == ACT_ENC)
			enc_sent++;
		else
			scan_sent++;
	endtask

	// Stop offering requests and wait until every owed key code has come out,
	// then let a request that produced nothing finish.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_keys.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Registers are only written while the block is idle, so the predictor can
	// take the new value right away.
	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			kdpc_pkg::REG_SHORT_PRESS:  cfg_now.short_press  = val[6:0];
			kdpc_pkg::REG_LONG_PRESS:   cfg_now.long_press   = val;
			kdpc_pkg::REG_RELEASE:      cfg_now.release_len  = val;
			kdpc_pkg::REG_DOUBLE_HIT:   cfg_now.double_hit   = val;
			kdpc_pkg::REG_POST_HOLDOFF: cfg_now.post_holdoff = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// The receiver accepts at random, except during a requested long stall, which
	// it counts out by itself while the sender keeps pushing.
	always @(posedge clk) begin
		if (stall_seen != stall_toggle) begin
			stall_seen = stall_toggle;
			stall_left = RX_STALL_CYCLES;
		end
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= ready_idle_pct);
		end
	end

	// Every key code that leaves the block must match the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_keys.size() == 0) begin
				errors++;
				$display("%0t: key_code expected none, actual %0d", $time, key_code);
			end else begin
				if (key_code !== expected_keys[0]) begin
					errors++;
					$display("%0t: key_code expected %0d, actual %0d", $time,
						expected_keys[0], key_code);
				end
				void'(expected_keys.pop_front());
			end
			keys_checked++;
		end
	end

	// The run is cut short if neither channel moves for too long.
	initial begin
		int unsigned quiet;

		quiet = 0;
		wait (arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		dir_row_t            directed_rows [$];
		kdpc_pkg::kdpc_cfg_t c;
		int unsigned         budget;
		int unsigned         start;
		int unsigned         pick;
		int unsigned         hold_len;
		int unsigned         rel_len;
		int unsigned         steps;
		bit                  paused;
		bit                  fwd;
		logic [3:0]          pat;

		cfg_now.short_press  = kdpc_pkg::SHORT_PRESS_RST;
		cfg_now.long_press   = kdpc_pkg::LONG_PRESS_RST;
		cfg_now.release_len  = kdpc_pkg::RELEASE_RST;
		cfg_now.double_hit   = kdpc_pkg::DOUBLE_HIT_RST;
		cfg_now.post_holdoff = kdpc_pkg::POST_HOLDOFF_RST;
		held_ticks    = 8'd0;
		release_run   = 8'd0;
		lockout_left  = 8'd0;
		spacing_left  = 8'd0;
		first_samples = '{4'h0, 4'h0, 4'h0};
		last_phase    = 2'b00;

		// Directed part. The first rows run at the reset settings: an encoder step
		// out of phase zero that emits nothing, a clockwise step that is emitted,
		// another step out of phase zero, and a counter-clockwise step that the spacing
		// swallows because encoder samples never count the spacing down.
		directed_rows.push_back(req_row(ACT_ENC, kdpc_pkg::PAT_NONE, 2'b01, 1'b1, 1'b0));
		directed_rows.push_back(req_row(ACT_ENC, kdpc_pkg::PAT_NONE, 2'b00, 1'b1, 1'b1,
			kdpc_pkg::KEY_CW));
		directed_rows.push_back(req_row(ACT_ENC, kdpc_pkg::PAT_NONE, 2'b01, 1'b1, 1'b0));
		directed_rows.push_back(req_row(ACT_ENC, kdpc_pkg::PAT_NONE, 2'b11, 1'b1, 1'b0));
		// Tightest settings. The short press value carries a stray top bit that the
		// block must mask off, and the spare indexes must change nothing.
		directed_rows.push_back(write_row(kdpc_pkg::REG_SHORT_PRESS, {1'b1, 7'd3}));
		directed_rows.push_back(write_row(kdpc_pkg::REG_LONG_PRESS, 8'd5));
		directed_rows.push_back(write_row(kdpc_pkg::REG_RELEASE, 8'd1));
		directed_rows.push_back(write_row(kdpc_pkg::REG_DOUBLE_HIT, 8'd0));
		directed_rows.push_back(write_row(kdpc_pkg::REG_POST_HOLDOFF, 8'd0));
		for (int i = REG_SPARE_FIRST; i < 8; i++)
			directed_rows.push_back(write_row(3'(i), 8'hFF));
		// All four buttons down is a pattern with no code.
		repeat (3) directed_rows.push_back(req_row(ACT_SCAN, 4'h0, 2'b11));
		directed_rows.push_back(req_row(ACT_SCAN, kdpc_pkg::PAT_NONE, 2'b00));
		// A short power press while the earlier spacing is still running.
		repeat (3) directed_rows.push_back(req_row(ACT_SCAN, kdpc_pkg::PAT_POWER, 2'b10));
		directed_rows.push_back(req_row(ACT_SCAN, kdpc_pkg::PAT_NONE, 2'b01));
		// Power and mode held to the long threshold.
		repeat (5)
			directed_rows.push_back(req_row(ACT_SCAN, kdpc_pkg::PAT_POWER_MODE, 2'b00));
		directed_rows.push_back(req_row(ACT_SCAN, kdpc_pkg::PAT_NONE, 2'b00));
		// A mode press that is too short, then finished by a further tick.
		repeat (2) directed_rows.push_back(req_row(ACT_SCAN, kdpc_pkg::PAT_MODE, 2'b01));
		directed_rows.push_back(req_row(ACT_SCAN, kdpc_pkg::PAT_NONE, 2'b10));
		directed_rows.push_back(req_row(ACT_SCAN, kdpc_pkg::PAT_MODE, 2'b11));
		directed_rows.push_back(req_row(ACT_SCAN, kdpc_pkg::PAT_NONE, 2'b00));
		// The step from 10 to 00 must count as counter-clockwise.
		directed_rows.push_back(req_row(ACT_ENC, 4'h0, 2'b10));
		directed_rows.push_back(req_row(ACT_ENC, 4'h0, 2'b00));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		settings_run = 2;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			end else begin
				send_request(directed_rows[i].act, directed_rows[i].btn, directed_rows[i].ab,
					directed_rows[i].typed, directed_rows[i].exp_emit,
					directed_rows[i].exp_code);
			end
		end

		// Random part, in phases. Each phase writes every register; fixed phases
		// cover the extremes and the reset values, the rest use small random values
		// so that presses are judged often. The first three phases idle the
		// receiver heavily, the next three the sender, the last three neither.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// Field order: short press, long press, release, double hit, holdoff.
			c.short_press  = 7'($urandom_range(3, 6));
			c.long_press   = 8'($urandom_range(5, 14));
			c.release_len  = 8'($urandom_range(1, 5));
			c.double_hit   = 8'($urandom_range(0, 3));
			c.post_holdoff = 8'($urandom_range(0, 5));
			case (ph)
				0: c = {7'd3, 8'd5, 8'd1, 8'd0, 8'd0};
				2: c = {7'd100, 8'd254, 8'd255, 8'd0, 8'd255};
				4: c = {7'd3, 8'd5, 8'd2, 8'd255, 8'd0};
				7: c = {kdpc_pkg::SHORT_PRESS_RST, kdpc_pkg::LONG_PRESS_RST,
					kdpc_pkg::RELEASE_RST, kdpc_pkg::DOUBLE_HIT_RST,
					kdpc_pkg::POST_HOLDOFF_RST};
				default: ;
			endcase
			valid_idle_pct = (ph < 3) ? 26 : (ph < 6) ? 69 : 0;
			ready_idle_pct <= (ph < 3) ? 69 : (ph < 6) ? 26 : 0;

			wait_idle();
			write_reg(kdpc_pkg::REG_SHORT_PRESS, {1'b0, c.short_press});
			write_reg(kdpc_pkg::REG_LONG_PRESS, c.long_press);
			write_reg(kdpc_pkg::REG_RELEASE, c.release_len);
			write_reg(kdpc_pkg::REG_DOUBLE_HIT, c.double_hit);
			write_reg(kdpc_pkg::REG_POST_HOLDOFF, c.post_holdoff);
			settings_run++;

			budget = (ph == 2) ? 520 : 85;
			start  = scan_sent + enc_sent;
			paused = 1'b0;
			while (scan_sent + enc_sent - start < budget) begin
				// Halfway through, let the block drain completely. In one phase the
				// receiver then stalls for a long stretch while requests keep coming.
				if (!paused && scan_sent + enc_sent - start >= budget / 2) begin
					paused = 1'b1;
					wait_idle();
					if (ph == 6)
						stall_toggle <= ~stall_toggle;
				end

				pick = $urandom_range(99);
				if (pick < 50) begin
					// A press: mostly a known pattern, sometimes bounced at the start, held around
					// the short or long threshold or for a random length, then released.
					if ($urandom_range(99) < 85) begin
						case ($urandom_range(5))
							0:       pat = kdpc_pkg::PAT_POWER;
							1:       pat = kdpc_pkg::PAT_MODE;
							2:       pat = kdpc_pkg::PAT_POWER_MODE;
							3:       pat = kdpc_pkg::PAT_RATE;
							4:       pat = kdpc_pkg::PAT_CENTER;
							default: pat = kdpc_pkg::PAT_CENTER_RATE;
						endcase
					end else begin
						pat = 4'($urandom_range(15));
					end
					if ($urandom_range(99) < 20)
						repeat ($urandom_range(1, 2))
							send_request(ACT_SCAN, 4'($urandom_range(15)),
								2'($urandom_range(3)));
					pick = $urandom_range(9);
					if (pick < 6)
						hold_len = cfg_now.short_press - 1 + $urandom_range(3);
					else if (pick < 8)
						hold_len = cfg_now.long_press - 1 + $urandom_range(4);
					else
						hold_len = $urandom_range(1, 12);
					repeat (hold_len) send_request(ACT_SCAN, pat, 2'($urandom_range(3)));
					if ($urandom_range(9) < 8)
						rel_len = cfg_now.release_len + $urandom_range(2);
					else
						rel_len = $urandom_range(1, cfg_now.release_len);
					repeat (rel_len)
						send_request(ACT_SCAN, kdpc_pkg::PAT_NONE, 2'($urandom_range(3)));
				end else if (pick < 80) begin
					// The encoder turns by quarter steps, now and then reversing or
					// jumping.
					steps = $urandom_range(4, 16);
					fwd   = 1'($urandom_range(1));
					repeat (steps) begin
						if ($urandom_range(99) < 15)
							fwd = ~fwd;
						if ($urandom_range(99) < 10)
							enc_last = 2'($urandom_range(3));
						else if (fwd)
							enc_last = {enc_last[0], ~enc_last[1]};
						else
							enc_last = {~enc_last[0], enc_last[1]};
						send_request(ACT_ENC, 4'($urandom_range(15)), enc_last);
					end
				end else begin
					// Noise: anything at all.
					repeat ($urandom_range(1, 8))
						send_request(1'($urandom_range(1)), 4'($urandom_range(15)),
							2'($urandom_range(3)));
				end
			end
		end

		wait_idle();
		$display("Ran %0d scan and %0d encoder requests under %0d register settings,",
			scan_sent, enc_sent, settings_run);
		$display("checked %0d key codes and found %0d mismatches.", keys_checked, errors);
		if (errors == 0 && expected_keys.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
